>>> hw/rtl/clcg_pkg.sv
package clcg_pkg;

    // Generator moduli sit just below 2^31: M = 2^31 - FOLD.
    localparam logic [30:0] MOD1         = 31'd2147483563;
    localparam logic [30:0] MOD2         = 31'd2147483399;
    localparam logic [7:0]  FOLD1        = 8'd85;
    localparam logic [7:0]  FOLD2        = 8'd249;
    localparam logic [15:0] MUL1         = 16'd40014;
    localparam logic [15:0] MUL2         = 16'd40692;
    localparam logic [31:0] SPAN1        = 32'd2147483562;
    localparam logic [30:0] SECOND_RESET = 31'd123456789;
    localparam logic [30:0] RAND_MAX_VAL = 31'd2147483562;

    // Request function codes
    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_KICK,
        ST_SEED_WAIT,
        ST_SEED_NEXT,
        ST_DRAW_GEN1,
        ST_DRAW_GEN2,
        ST_DRAW_INDEX,
        ST_DRAW_READ,
        ST_DRAW_DONE
    } t_state;

    typedef struct packed {
        logic load_seed;
        logic mm_go;
        logic mm_second;
        logic cnt_dec;
        logic seed_wr;
        logic load_last;
        logic draw_fin;
    } t_cmd;

    typedef struct packed {
        logic mm_done;
        logic cnt_zero;
    } t_status;

endpackage

>>> hw/rtl/clcg_modmul.sv
module clcg_modmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_second,
    input  logic [30:0] i_operand,
    output logic        o_done,
    output logic        o_second,
    output logic [30:0] o_result
);
    import clcg_pkg::*;

    logic [46:0] r_prod;
    logic        r_v1;
    logic        r_sec1;
    logic [31:0] r_sum;
    logic        r_v2;
    logic        r_sec2;

    logic [15:0] mul_c;
    logic [7:0]  fold1_c;
    logic [7:0]  fold2_c;
    logic [30:0] mod2_c;
    logic [23:0] hi_fold;
    logic [31:0] n_sum;
    logic [31:0] folded;

    // Stage 1: product of state and multiplier
    assign mul_c = i_second ? MUL2 : MUL1;

    always_ff @(posedge i_clk) begin
        r_prod <= 47'(i_operand) * 47'(mul_c);
        r_sec1 <= i_second;
        r_sec2 <= r_sec1;
        r_sum  <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
        end
    end

    // Stage 2: fold the bits above 2^31 back in (2^31 == FOLD mod M)
    assign fold1_c = r_sec1 ? FOLD2 : FOLD1;
    assign hi_fold = 24'(r_prod[46:31]) * 24'(fold1_c);
    assign n_sum   = 32'(r_prod[30:0]) + 32'(hi_fold);

    // Stage 3: second fold, then one conditional subtract
    assign fold2_c = r_sec2 ? FOLD2 : FOLD1;
    assign mod2_c  = r_sec2 ? MOD2 : MOD1;
    assign folded  = 32'(r_sum[30:0]) + (r_sum[31] ? 32'(fold2_c) : 32'd0);

    always_comb begin
        if (folded >= 32'(mod2_c)) begin
            o_result = 31'(folded - 32'(mod2_c));
        end else begin
            o_result = folded[30:0];
        end
    end

    assign o_done   = r_v2;
    assign o_second = r_sec2;

endmodule

>>> hw/rtl/clcg_datapath.sv
module clcg_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [30:0]       i_seed_value,
    input  clcg_pkg::t_cmd    i_cmd,
    output clcg_pkg::t_status o_status,
    output logic              o_valid,
    output logic [30:0]       o_random_value
);
    import clcg_pkg::*;

    localparam int TW  = $clog2(TABLE_DEPTH);
    localparam int QW  = TW + 1;
    localparam int QPW = 31 + QW;
    localparam int THW = 32 + QW;
    localparam int CW  = $clog2(TABLE_DEPTH + 8);
    localparam logic [31:0]   BUCKET    = 32'(1 + SPAN1 / TABLE_DEPTH);
    localparam logic [QW-1:0] DEPTH_Q   = QW'(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] CNT_START = CW'(TABLE_DEPTH + 7);
    localparam logic [TW-1:0] IDX_LAST  = TW'(TABLE_DEPTH - 1);

    logic [30:0] r_first,  n_first;
    logic [30:0] r_second, n_second;
    logic [30:0] r_last,   n_last;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic        r_out_vld;

    logic [30:0] r_tab [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_tab_vld;
    logic [30:0] r_rd_data;
    logic        r_rd_vld;

    logic [QW-1:0]  r_qest;
    logic [30:0]    r_x1;
    logic [THW-1:0] r_thr;
    logic [QW-1:0]  r_q2;
    logic [30:0]    r_x2;
    logic [TW-1:0]  r_idx, n_idx;

    logic        mm_done;
    logic        mm_second;
    logic [30:0] mm_res;
    logic [30:0] mm_operand;
    logic [30:0] seed_fix;
    logic [QPW-1:0] qprod;
    logic [QW:0]    q_inc;
    logic [QW:0]    q_fix;
    logic           wr_en;
    logic [TW-1:0]  wr_addr;
    logic [30:0]    tab_val;
    logic [31:0]    diff;
    logic [31:0]    wrapped;

    assign mm_operand = i_cmd.mm_second ? r_second : r_first;

    clcg_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (i_cmd.mm_go),
        .i_second  (i_cmd.mm_second),
        .i_operand (mm_operand),
        .o_done    (mm_done),
        .o_second  (mm_second),
        .o_result  (mm_res)
    );

    assign seed_fix = (i_seed_value == 31'd0) ? 31'd1 : i_seed_value;

    // Bucket index: estimate x*D/2^31, which is the quotient or one short of it
    assign qprod = QPW'(r_last) * QPW'(DEPTH_Q);
    assign q_inc = {1'b0, r_qest} + (QW+1)'(1);
    assign q_fix = {1'b0, r_q2} + ((THW'(r_x2) >= r_thr) ? (QW+1)'(1) : (QW+1)'(0));

    always_comb begin
        if (q_fix >= {1'b0, DEPTH_Q}) begin
            n_idx = IDX_LAST;
        end else begin
            n_idx = q_fix[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_qest <= qprod[QPW-1:31];
        r_x1   <= r_last;
        r_thr  <= THW'(q_inc) * THW'(BUCKET);
        r_q2   <= r_qest;
        r_x2   <= r_x1;
        r_idx  <= n_idx;
    end

    // Draw result: entry minus second generator, wrapped into 1..SPAN1
    assign tab_val = r_rd_vld ? r_rd_data : 31'd0;
    assign diff    = {1'b0, tab_val} - {1'b0, r_second};
    assign wrapped = (diff[31] || diff == 32'd0) ? diff + SPAN1 : diff;

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_last   = r_last;
        n_cnt    = r_cnt;
        if (i_cmd.load_seed) begin
            n_first  = seed_fix;
            n_second = seed_fix;
            n_cnt    = CNT_START;
        end else if (mm_done) begin
            if (mm_second) begin
                n_second = mm_res;
            end else begin
                n_first = mm_res;
            end
        end
        if (i_cmd.cnt_dec) begin
            n_cnt = r_cnt - CW'(1);
        end
        if (i_cmd.load_last) begin
            n_last = r_first;
        end else if (i_cmd.draw_fin) begin
            n_last = wrapped[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 31'd0;
            r_second  <= SECOND_RESET;
            r_last    <= 31'd0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_tab_vld <= '0;
        end else begin
            r_first   <= n_first;
            r_second  <= n_second;
            r_last    <= n_last;
            r_cnt     <= n_cnt;
            r_out_vld <= i_cmd.draw_fin;
            if (wr_en) begin
                r_tab_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Shuffle table: one write port, one registered read port
    assign wr_en   = (i_cmd.seed_wr && (r_cnt < DEPTH_C)) || i_cmd.draw_fin;
    assign wr_addr = i_cmd.draw_fin ? r_idx : r_cnt[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tab[wr_addr] <= r_first;
        end
        r_rd_data <= r_tab[r_idx];
        r_rd_vld  <= r_tab_vld[r_idx];
    end

    assign o_status.mm_done  = mm_done;
    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_valid           = r_out_vld;
    assign o_random_value    = r_last;

endmodule

>>> hw/rtl/clcg_ctrl.sv
module clcg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_func,
    input  clcg_pkg::t_status i_status,
    output clcg_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import clcg_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_func == FUNC_RESEED) begin
                        o_cmd.load_seed = 1'b1;
                        n_state = ST_SEED_KICK;
                    end else begin
                        n_state = ST_DRAW_GEN1;
                    end
                end
            end
            ST_SEED_KICK: begin
                o_cmd.mm_go = 1'b1;
                n_state = ST_SEED_WAIT;
            end
            ST_SEED_WAIT: begin
                if (i_status.mm_done) begin
                    n_state = ST_SEED_NEXT;
                end
            end
            ST_SEED_NEXT: begin
                o_cmd.seed_wr = 1'b1;
                if (i_status.cnt_zero) begin
                    o_cmd.load_last = 1'b1;
                    n_state = ST_DRAW_GEN1;
                end else begin
                    o_cmd.mm_go   = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state = ST_SEED_WAIT;
                end
            end
            ST_DRAW_GEN1: begin
                o_cmd.mm_go = 1'b1;
                n_state = ST_DRAW_GEN2;
            end
            ST_DRAW_GEN2: begin
                o_cmd.mm_go     = 1'b1;
                o_cmd.mm_second = 1'b1;
                n_state = ST_DRAW_INDEX;
            end
            ST_DRAW_INDEX: begin
                n_state = ST_DRAW_READ;
            end
            ST_DRAW_READ: begin
                n_state = ST_DRAW_DONE;
            end
            ST_DRAW_DONE: begin
                o_cmd.draw_fin = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> hw/rtl/combined_lcg_rng_shuffled.sv
// Combined two-generator congruential RNG with a shuffle table.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. i_func selects reseed-then-draw or draw only; i_seed_value is
// sampled only at that edge (zero acts as one).
// Result channel: o_valid is high for exactly one cycle with o_random_value
// (1..2147483562). The receiver cannot stall; it must take the value then.
//
// Sequencing: a draw steps both generators, forms the table index, reads the
// table entry and then strobes o_valid; a reseed adds a warm-up ahead of
// it, set by the first generator stepping through the three-stage modular
// multiply pipeline, each step waiting on the previous one. busy drops in
// the strobe cycle, so the next request can be taken there; a request is
// taken only while busy is low, so requests are handled one at a time.
//
// Reset (synchronous, active low): generators go to 0 and 123456789, last
// output to 0, and every table entry reads as zero until it is written.
module combined_lcg_rng_shuffled #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        i_func,
    input  logic [30:0] i_seed_value,
    output logic        busy,
    output logic        o_valid,
    output logic [30:0] o_random_value
);
    import clcg_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence reseed warm-up and draw steps
    clcg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold generator state, the shuffle table and the index pipeline
    clcg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_value   (i_seed_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

    // A result never shows while a request is still in flight
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Wrapped result stays inside 1..SPAN1
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_random_value != 31'd0 && o_random_value <= RAND_MAX_VAL))
        else $error("result outside its range");

    // A draw-only request is always followed by its result strobe
    a_draw_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_DRAW) |-> ##6 o_valid)
        else $error("draw result missing");

endmodule

>>> tb/combined_lcg_rng_shuffled_tb.sv
module combined_lcg_rng_shuffled_tb;
    import clcg_pkg::*;

    // Shuffle table depth of the instance; the model state below follows it.
    localparam int          TBL_DEPTH = 32;
    // Width of one table bucket in output space: last output / BUCKET picks the slot.
    localparam logic [31:0] BUCKET    = 32'd1 + SPAN1 / 32'(TBL_DEPTH);
    // Edge seeds: zero (acts as one), one, around the second modulus, top of range.
    localparam logic [30:0] SEED_EDGES [5] = '{31'd0, 31'd1, MOD2 - 31'd1, MOD2, RAND_MAX_VAL};

    typedef struct {
        logic        func;
        logic [30:0] seed;
    } rng_req_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        i_func       = FUNC_DRAW;
    logic [30:0] i_seed_value = '0;
    logic        busy;
    logic        o_valid;
    logic [30:0] o_random_value;

    // Pending requests for the driver, and draws still owed by the block.
    rng_req_t    req_q[$];
    logic [30:0] rand_exp_q[$];

    // Mirror of the generator state: both LCGs, the shuffle table, last output.
    logic [30:0] gen1;
    logic [30:0] gen2;
    logic [30:0] shuf_tbl [TBL_DEPTH];
    logic [30:0] prev_rand;

    // Handshake seen at the last rising edge, read by the driver at the next fall.
    logic        req_taken = 1'b0;
    int          burst_left;
    int          gap_left;

    int          fail_cnt    = 0;
    int          reseed_cnt  = 0;
    int          draw_cnt    = 0;
    int          checked_cnt = 0;
    logic [TBL_DEPTH-1:0] slot_hit = '0;

    combined_lcg_rng_shuffled #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_func        (i_func),
        .i_seed_value  (i_seed_value),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_random_value(o_random_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One multiplicative congruential step, reduced exactly for any 31-bit state.
    function automatic logic [30:0] lcg_next(input logic [30:0] x, input logic [15:0] mul,
                                             input logic [30:0] md);
        logic [63:0] prod;
        prod = {33'd0, x} * {48'd0, mul};
        return 31'(prod % {33'd0, md});
    endfunction

    // Reload both generators from the seed, run the warm-up, refill the table.
    task automatic reseed_gens(input logic [30:0] seed);
        logic [30:0] s;
        int          j;
        s    = (seed == '0) ? 31'd1 : seed;
        gen1 = s;
        gen2 = s;
        for (j = TBL_DEPTH + 7; j >= 0; j--) begin
            gen1 = lcg_next(gen1, MUL1, MOD1);
            if (j < TBL_DEPTH)
                shuf_tbl[j] = gen1;
        end
        prev_rand = shuf_tbl[0];
    endtask

    // Advance both generators, read and refill one slot, return the new draw.
    function automatic logic [30:0] draw_rand();
        logic [31:0] slot;
        longint      diff;
        gen1 = lcg_next(gen1, MUL1, MOD1);
        gen2 = lcg_next(gen2, MUL2, MOD2);
        slot = {1'b0, prev_rand} / BUCKET;
        // Saturate a slot past the end; BUCKET times the depth exceeds SPAN1, so none is reached.
        if (slot >= 32'(TBL_DEPTH))
            slot = 32'(TBL_DEPTH - 1);
        slot_hit[slot] = 1'b1;
        diff = longint'(shuf_tbl[slot]) - longint'(gen2);
        if (diff < 1)
            diff += longint'(SPAN1);
        shuf_tbl[slot] = gen1;
        prev_rand      = diff[30:0];
        return prev_rand;
    endfunction

    task automatic add_req(input logic func, input logic [30:0] seed);
        rng_req_t r;
        r.func = func;
        r.seed = seed;
        req_q.push_back(r);
    endtask

    // Driver: change inputs on the falling edge. Hold a request until the block
    // takes it, then either idle for the gap that ends a burst or present the
    // next request straight away so that start stays high across requests.
    always @(negedge i_clk) begin
        rng_req_t cur;
        if (i_rst_n && !(start && !req_taken)) begin
            if (gap_left > 0 || req_q.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end else begin
                cur = req_q.pop_front();
                start        <= 1'b1;
                i_func       <= cur.func;
                i_seed_value <= cur.seed;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    // Roughly one burst in four runs on with no idle cycles at all.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Monitor: sample on the rising edge. Check the strobe against the oldest
    // owed draw first, since a new request can be taken in the strobe cycle.
    always @(posedge i_clk) begin
        logic [30:0] want;
        if (!i_rst_n) begin
            gen1      = '0;
            gen2      = SECOND_RESET;
            prev_rand = '0;
            foreach (shuf_tbl[k])
                shuf_tbl[k] = '0;
            req_taken = 1'b0;
        end else begin
            if ($isunknown(o_valid)) begin
                $display("%0t: o_valid unknown, expected 0 or 1, got %b", $time, o_valid);
                fail_cnt++;
            end else if (o_valid) begin
                if (rand_exp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, o_random_value);
                    fail_cnt++;
                end else begin
                    want = rand_exp_q.pop_front();
                    checked_cnt++;
                    if (o_random_value !== want) begin
                        $display("%0t: random_value mismatch, expected %0d, got %0d",
                                 $time, want, o_random_value);
                        fail_cnt++;
                    end
                end
            end
            req_taken = start && !busy;
            if (req_taken) begin
                if (i_func == FUNC_RESEED) begin
                    reseed_gens(i_seed_value);
                    reseed_cnt++;
                end else begin
                    draw_cnt++;
                end
                rand_exp_q.push_back(draw_rand());
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int          n;
        logic        func;
        logic [30:0] seed;

        burst_left = $urandom_range(1, 40);
        gap_left   = 0;

        // Draws on the reset state, before any seed: first generator stuck at zero.
        add_req(FUNC_DRAW, 31'd0);
        add_req(FUNC_DRAW, RAND_MAX_VAL);
        // Zero seed acts as one; compare against an explicit one.
        add_req(FUNC_RESEED, 31'd0);
        add_req(FUNC_DRAW, 31'd0);
        add_req(FUNC_RESEED, 31'd1);
        // Seeds just below and at the second modulus, reduced by its first step.
        add_req(FUNC_RESEED, MOD2 - 31'd1);
        add_req(FUNC_RESEED, MOD2);
        add_req(FUNC_DRAW, 31'd0);
        add_req(FUNC_RESEED, RAND_MAX_VAL);
        add_req(FUNC_DRAW, 31'h2AAA_AAAA);
        add_req(FUNC_DRAW, 31'h5555_5555);
        add_req(FUNC_RESEED, 31'h2AAA_AAAA);
        add_req(FUNC_RESEED, 31'h5555_5555);
        // A run of draws with junk on the seed pins, which a draw must ignore.
        repeat (8)
            add_req(FUNC_DRAW, 31'($urandom));

        // Random part: mostly draw chains, with an occasional reseed to restart
        // the sequence from a fresh table.
        for (n = 0; n < 750; n++) begin
            func = ($urandom_range(0, 11) == 0) ? FUNC_RESEED : FUNC_DRAW;
            if (func == FUNC_RESEED && $urandom_range(0, 7) == 0)
                seed = SEED_EDGES[$urandom_range(0, 4)];
            else
                seed = 31'($urandom_range(0, 32'(RAND_MAX_VAL)));
            add_req(func, seed);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (req_q.size() != 0 || start || rand_exp_q.size() != 0)
            @(posedge i_clk);
        // Allow a full reseed latency for any stray strobe.
        repeat (200) @(posedge i_clk);

        $display("Covered %0d reseed and %0d draw requests, %0d results checked.",
                 reseed_cnt, draw_cnt, checked_cnt);
        $display("Shuffle slots read: %0d of %0d.", $countones(slot_hit), TBL_DEPTH);
        if (fail_cnt == 0 && rand_exp_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(8 * 400000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
